### rtl/core/utf8ld_pkg.sv
package utf8ld_pkg;

    localparam int BYTE_W  = 8;
    localparam int POINT_W = 21;

    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD2_BITS = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_BITS = 8'h0F;
    localparam logic [BYTE_W-1:0] LEAD4_BITS = 8'h07;
    localparam logic [BYTE_W-1:0] TAIL_BITS  = 8'h3F;

    typedef struct packed {
        logic [POINT_W-1:0] code_point;
        logic               point_valid;
        logic               string_done;
        logic               run_last;
    } result_t;

    typedef struct packed {
        logic [1:0]         needed;
        logic               held;
        logic [POINT_W-1:0] accum;
        logic [BYTE_W-1:0]  follower;
    } dec_state_t;

endpackage

### rtl/core/utf8ld_if.sv
interface utf8ld_byte_if
    import utf8ld_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_in;
    logic              final_byte;

    modport source (output valid, output byte_in, output final_byte, input ready);
    modport sink (input valid, input byte_in, input final_byte, output ready);
endinterface

interface utf8ld_point_if
    import utf8ld_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [POINT_W-1:0] code_point;
    logic               point_valid;
    logic               string_done;
    logic               run_last;

    modport source (output valid, output code_point, output point_valid,
                    output string_done, output run_last, input ready);
    modport sink (input valid, input code_point, input point_valid,
                  input string_done, input run_last, output ready);
endinterface

### rtl/core/utf8ld_step.sv
module utf8ld_step
    import utf8ld_pkg::*;
(
    input  logic [BYTE_W-1:0] byte_in,
    input  logic              final_byte,
    input  dec_state_t        state,
    output dec_state_t        state_next,
    output result_t           res0,
    output result_t           res1,
    output logic [1:0]        res_count
);

    logic               v0;
    logic               v1;
    logic [POINT_W-1:0] p0;
    logic [POINT_W-1:0] p1;
    logic [POINT_W-1:0] acc_shift;
    logic [1:0]         need_dec;
    logic [BYTE_W-1:0]  lead_bits;

    assign acc_shift = {state.accum[POINT_W-7:0], byte_in[5:0]};
    assign need_dec  = state.needed - 2'd1;

    always_comb
    begin
        state_next = state;
        v0 = 1'b0;
        v1 = 1'b0;
        p0 = '0;
        p1 = '0;
        lead_bits = '0;
        if (state.needed == 2'd0)
        begin
            state_next.held = 1'b0;
            case (byte_in) inside
                [8'h00:8'h7F]:
                begin
                    v0 = 1'b1;
                    p0 = {{(POINT_W-BYTE_W){1'b0}}, byte_in};
                end
                [8'hC0:8'hDF]:
                begin
                    lead_bits = byte_in & LEAD2_BITS;
                    state_next.accum  = {{(POINT_W-BYTE_W){1'b0}}, lead_bits};
                    state_next.needed = 2'd1;
                end
                [8'hE0:8'hEF]:
                begin
                    lead_bits = byte_in & LEAD3_BITS;
                    state_next.accum  = {{(POINT_W-BYTE_W){1'b0}}, lead_bits};
                    state_next.needed = 2'd2;
                end
                [8'hF0:8'hF7]:
                begin
                    lead_bits = byte_in & LEAD4_BITS;
                    state_next.accum  = {{(POINT_W-BYTE_W){1'b0}}, lead_bits};
                    state_next.needed = 2'd3;
                end
                default:
                begin
                    // stray lead, skipped
                end
            endcase
        end
        else
        begin
            state_next.accum  = acc_shift;
            state_next.needed = need_dec;
            if (need_dec == 2'd0)
            begin
                v0 = 1'b1;
                p0 = acc_shift;
                state_next.held = 1'b0;
            end
            else if (final_byte)
            begin
                // string cut inside a sequence: decode held byte and this one again
                if (state.held)
                begin
                    if (!state.follower[7])
                    begin
                        v0 = 1'b1;
                        p0 = {{(POINT_W-BYTE_W){1'b0}}, state.follower};
                        if (!byte_in[7])
                        begin
                            v1 = 1'b1;
                            p1 = {{(POINT_W-BYTE_W){1'b0}}, byte_in};
                        end
                    end
                    else if ((state.follower & LEAD2_MASK) == LEAD2_CODE)
                    begin
                        v0 = 1'b1;
                        p0 = {{(POINT_W-11){1'b0}}, state.follower[4:0],
                              byte_in[5:0]};
                    end
                    else if (!byte_in[7])
                    begin
                        v0 = 1'b1;
                        p0 = {{(POINT_W-BYTE_W){1'b0}}, byte_in};
                    end
                end
                else if (!byte_in[7])
                begin
                    v0 = 1'b1;
                    p0 = {{(POINT_W-BYTE_W){1'b0}}, byte_in};
                end
            end
            else if (!state.held)
            begin
                state_next.follower = byte_in & 8'hFF;
                state_next.held     = 1'b1;
            end
        end
        if (final_byte)
        begin
            state_next.needed = 2'd0;
            state_next.held   = 1'b0;
            state_next.accum  = '0;
        end
    end

    always_comb
    begin
        res0 = '{code_point: p0, point_valid: 1'b1, string_done: final_byte,
                 run_last: !v1};
        res1 = '{code_point: p1, point_valid: 1'b1, string_done: final_byte,
                 run_last: 1'b1};
        if (!v0)
        begin
            if (final_byte)
            begin
                res0 = '{code_point: '0, point_valid: 1'b0, string_done: 1'b1,
                         run_last: 1'b1};
                res_count = 2'd1;
            end
            else
            begin
                res_count = 2'd0;
            end
        end
        else if (v1)
        begin
            res_count = 2'd2;
        end
        else
        begin
            res_count = 2'd1;
        end
    end

endmodule

### rtl/core/utf8_lenient_decoder_core.sv
// Lenient UTF-8 decoder: one byte beat in, zero to two code point beats out.
// A byte can be accepted in every cycle while the result queue has room; its
// results are registered into a three-entry result queue and leave it one per
// cycle while the output is ready. The input is held off whenever two or more
// results would still wait after the current cycle's output beat, so a byte
// that gives two points (a string cut inside a sequence) uses two queue entries.
// Bytes after a lead are not checked as continuation bytes; stray leads give no
// point; the final byte of a string always gives at least one beat, possibly an
// empty end marker with point_valid low, and clears all sequence state.
module utf8_lenient_decoder_core
    import utf8ld_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    utf8ld_byte_if.sink   in_bytes,
    utf8ld_point_if.source out_points
);

    dec_state_t state;
    dec_state_t state_next;
    result_t    res0;
    result_t    res1;
    logic [1:0] res_count;

    logic [1:0]         needed_reg;
    logic               held_reg;
    logic [POINT_W-1:0] accum_reg;
    logic [BYTE_W-1:0]  follower_reg;

    result_t    q_reg [3];
    result_t    q_next [3];
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic [1:0] base;

    logic push;
    logic pop;

    assign state = '{needed: needed_reg, held: held_reg, accum: accum_reg,
                     follower: follower_reg};

    utf8ld_step u_step (
        .byte_in    (in_bytes.byte_in),
        .final_byte (in_bytes.final_byte),
        .state      (state),
        .state_next (state_next),
        .res0       (res0),
        .res1       (res1),
        .res_count  (res_count)
    );

    assign pop  = out_points.valid && out_points.ready;
    assign in_bytes.ready = (count_reg == 2'd0) || (count_reg == 2'd1)
                            || ((count_reg == 2'd2) && pop);
    assign push = in_bytes.valid && in_bytes.ready;

    assign out_points.valid       = count_reg != 2'd0;
    assign out_points.code_point  = q_reg[0].code_point;
    assign out_points.point_valid = q_reg[0].point_valid;
    assign out_points.string_done = q_reg[0].string_done;
    assign out_points.run_last    = q_reg[0].run_last;

    always_comb
    begin
        q_next     = q_reg;
        count_next = count_reg;
        if (pop)
        begin
            q_next[0]  = q_reg[1];
            q_next[1]  = q_reg[2];
            count_next = count_reg - 2'd1;
        end
        base = count_next;
        if (push)
        begin
            if (res_count != 2'd0)
            begin
                q_next[base] = res0;
            end
            if (res_count == 2'd2)
            begin
                q_next[2'(base + 2'd1)] = res1;
            end
            count_next = count_next + res_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            needed_reg <= 2'd0;
            held_reg   <= 1'b0;
            accum_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                needed_reg <= state_next.needed;
                held_reg   <= state_next.held;
                accum_reg  <= state_next.accum;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        if (push)
        begin
            follower_reg <= state_next.follower;
        end
    end

    // head beat holds while the output stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        out_points.valid && !out_points.ready |=> out_points.valid
            && $stable(out_points.code_point) && $stable(out_points.run_last))
        else $error("output beat changed while stalled");

    // a byte is taken only with room for two results
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < 2'd2) || ((count_reg == 2'd2) && pop))
        else $error("byte accepted without queue room");

    // final byte clears the sequence state
    assert property (@(posedge clk) disable iff (!rst_n)
        push && in_bytes.final_byte |=> needed_reg == 2'd0 && !held_reg
            && accum_reg == '0)
        else $error("state not cleared after final byte");

    // final byte always leaves a beat in the queue
    assert property (@(posedge clk) disable iff (!rst_n)
        push && in_bytes.final_byte |=> count_reg != 2'd0)
        else $error("final byte gave no result");

endmodule

### test/utf8ld_tb_pkg.sv
package utf8ld_tb_pkg;

    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] TAIL_CODE   = 8'h80;
    localparam logic [7:0] TAIL_TOP    = 8'hBF;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_CODE  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK  = 8'hF8;
    localparam logic [7:0] LEAD4_CODE  = 8'hF0;
    localparam logic [7:0] STRAY_HIGH  = 8'hF8;

endpackage

### test/utf8ld_decode_checker.sv
module utf8ld_decode_checker
    import utf8ld_pkg::*;
    import utf8ld_tb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    utf8ld_byte_if  byte_mon,
    utf8ld_point_if point_mon,
    output int      fail_count,
    output int      pending,
    output int      points_seen,
    output int      markers_seen
);

    result_t          expected_points [$];
    logic [1:0]       open_left;
    logic [1:0]       kept_count;
    logic [POINT_W-1:0] partial_point;
    logic [7:0]       kept_bytes [2];
    int               mismatches;
    int               point_total;
    int               marker_total;

    function automatic result_t make_point(input logic [POINT_W-1:0] cp,
                                           input logic pv, input logic done);
        result_t r;
        r.code_point  = cp;
        r.point_valid = pv;
        r.string_done = done;
        r.run_last    = 1'b0;
        return r;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic fin);
        result_t    made [2];
        logic [7:0] tail [2];
        int         n;
        int         m;
        int         i;
        n = 0;
        if (open_left == 2'd0)
        begin
            kept_count = 2'd0;
            if (b < ASCII_LIMIT)
            begin
                made[n] = make_point({13'd0, b}, 1'b1, fin);
                n++;
            end
            else if ((b & LEAD2_MASK) == LEAD2_CODE)
            begin
                partial_point = {16'd0, b[4:0]};
                open_left = 2'd1;
            end
            else if ((b & LEAD3_MASK) == LEAD3_CODE)
            begin
                partial_point = {17'd0, b[3:0]};
                open_left = 2'd2;
            end
            else if ((b & LEAD4_MASK) == LEAD4_CODE)
            begin
                partial_point = {18'd0, b[2:0]};
                open_left = 2'd3;
            end
        end
        else
        begin
            partial_point = {partial_point[POINT_W-7:0], b[5:0]};
            open_left = open_left - 2'd1;
            if (open_left == 2'd0)
            begin
                made[n] = make_point(partial_point, 1'b1, fin);
                n++;
                kept_count = 2'd0;
            end
            else if (fin)
            begin
                // string cut inside a sequence: re-decode held follower and this byte
                m = 0;
                if (kept_count != 2'd0)
                begin
                    tail[m] = kept_bytes[0];
                    m++;
                end
                tail[m] = b;
                m++;
                i = 0;
                while (i < m)
                begin
                    if (tail[i] < ASCII_LIMIT)
                    begin
                        made[n] = make_point({13'd0, tail[i]}, 1'b1, 1'b1);
                        n++;
                        i++;
                    end
                    else if ((tail[i] & LEAD2_MASK) == LEAD2_CODE && i + 1 < m)
                    begin
                        made[n] = make_point({10'd0, tail[i][4:0], tail[i+1][5:0]},
                                             1'b1, 1'b1);
                        n++;
                        i += 2;
                    end
                    else
                    begin
                        i++;
                    end
                end
            end
            else if (kept_count < 2'd2)
            begin
                kept_bytes[kept_count[0]] = b;
                kept_count = kept_count + 2'd1;
            end
        end
        if (fin)
        begin
            kept_count = 2'd0;
            open_left = 2'd0;
            partial_point = '0;
            if (n == 0)
            begin
                made[n] = make_point('0, 1'b0, 1'b1);
                n++;
            end
        end
        if (n > 0)
            made[n-1].run_last = 1'b1;
        for (i = 0; i < n; i++)
            expected_points = {expected_points, made[i]};
    endfunction

    function automatic void report(input string what, input result_t want,
                                   input result_t got);
        mismatches++;
        if (mismatches <= 10)
            $display({"%0t %s: expected cp=%06h valid=%0b done=%0b last=%0b, ",
                      "got cp=%06h valid=%0b done=%0b last=%0b"},
                     $time, what, want.code_point, want.point_valid, want.string_done,
                     want.run_last, got.code_point, got.point_valid, got.string_done,
                     got.run_last);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            expected_points.delete();
            open_left = 2'd0;
            kept_count = 2'd0;
            partial_point = '0;
            kept_bytes[0] = '0;
            kept_bytes[1] = '0;
            mismatches = 0;
            point_total = 0;
            marker_total = 0;
        end
        else
        begin
            if (byte_mon.valid && byte_mon.ready)
                decode_byte(byte_mon.byte_in, byte_mon.final_byte);
            if (point_mon.valid && point_mon.ready)
            begin
                got.code_point  = point_mon.code_point;
                got.point_valid = point_mon.point_valid;
                got.string_done = point_mon.string_done;
                got.run_last    = point_mon.run_last;
                if (got.point_valid)
                    point_total++;
                else
                    marker_total++;
                if (expected_points.size() == 0)
                begin
                    report("unexpected beat", '0, got);
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (got.code_point !== want.code_point
                        || got.point_valid !== want.point_valid
                        || got.string_done !== want.string_done
                        || got.run_last !== want.run_last)
                        report("mismatch", want, got);
                end
            end
        end
        fail_count   <= mismatches;
        pending      <= expected_points.size();
        points_seen  <= point_total;
        markers_seen <= marker_total;
    end

endmodule

### test/tb_utf8_lenient_decoder_core.sv
module tb_utf8_lenient_decoder_core;
    import utf8ld_pkg::*;
    import utf8ld_tb_pkg::*;

    localparam int ITEM_TARGET    = 1150;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    // {final, byte}
    localparam logic [8:0] DIRECTED [26] = '{
        {1'b0, 8'h00}, {1'b0, 8'h7F}, {1'b1, 8'h41},
        {1'b0, 8'hC3}, {1'b1, 8'hA9},
        {1'b0, 8'hEF}, {1'b0, 8'hBF}, {1'b1, 8'hBF},
        {1'b0, 8'hF7}, {1'b0, 8'hFF}, {1'b0, 8'hFF}, {1'b1, 8'hFF},
        {1'b0, 8'hFF}, {1'b0, 8'hF8}, {1'b1, 8'h41},
        {1'b1, 8'hBF},
        {1'b1, 8'hE0},
        {1'b0, 8'hF0}, {1'b0, 8'h41}, {1'b1, 8'h42},
        {1'b0, 8'hF0}, {1'b0, 8'hC5}, {1'b1, 8'h85},
        {1'b0, 8'hF0}, {1'b0, 8'h80}, {1'b1, 8'h90}
    };

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   points_seen;
    int   markers_seen;
    int   bytes_sent;
    int   strings_sent;
    int   idle_cycles;
    bit   no_gaps;
    bit   hold_now;
    bit   hold_taken;

    utf8ld_byte_if  byte_ch ();
    utf8ld_point_if point_ch ();

    utf8_lenient_decoder_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_bytes   (byte_ch),
        .out_points (point_ch)
    );

    utf8ld_decode_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_mon     (byte_ch),
        .point_mon    (point_ch),
        .fail_count   (fail_count),
        .pending      (pending),
        .points_seen  (points_seen),
        .markers_seen (markers_seen)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] lead_byte(input int followers);
        logic [7:0] r;
        r = 8'($urandom_range(0, 255));
        if (followers == 1)
            return LEAD2_CODE | (r & LEAD2_BITS);
        if (followers == 2)
            return LEAD3_CODE | (r & LEAD3_BITS);
        return LEAD4_CODE | (r & LEAD4_BITS);
    endfunction

    function automatic logic [7:0] follower();
        logic [7:0] r;
        r = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 85)
            return TAIL_CODE | (r & TAIL_BITS);
        return r;
    endfunction

    function automatic logic [7:0] stray_lead();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(TAIL_CODE, TAIL_TOP));
        return 8'($urandom_range(STRAY_HIGH, 8'hFF));
    endfunction

    // bytes held after a cut lead: mix of ascii, 2-byte leads, continuation bytes and anything
    function automatic logic [7:0] cut_tail();
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(0, ASCII_LIMIT - 1));
            1: return lead_byte(1);
            2: return TAIL_CODE | (8'($urandom_range(0, 255)) & TAIL_BITS);
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        byte_ch.valid      <= 1'b1;
        byte_ch.byte_in    <= b;
        byte_ch.final_byte <= fin;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        bytes_sent++;
        if (fin)
            strings_sent++;
        gap = no_gaps ? 0 : idle_gap();
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_text();
        logic [7:0] text [$];
        int         nchars;
        int         kind;
        int         want;
        int         i;
        nchars = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
        for (i = 0; i < nchars; i++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 35)
            begin
                text = {text, 8'($urandom_range(0, ASCII_LIMIT - 1))};
            end
            else if (kind < 92)
            begin
                want = (kind < 57) ? 1 : ((kind < 77) ? 2 : 3);
                text = {text, lead_byte(want)};
                repeat (want) text = {text, follower()};
            end
            else if (kind < 96)
            begin
                text = {text, stray_lead()};
            end
            else
            begin
                text = {text, 8'($urandom_range(0, 255))};
            end
        end
        if ($urandom_range(0, 99) < 30)
        begin
            want = $urandom_range(1, 3);
            text = {text, lead_byte(want)};
            repeat ($urandom_range(0, want - 1)) text = {text, cut_tail()};
        end
        for (i = 0; i < text.size(); i++)
            send_byte(text[i], i == text.size() - 1);
    endtask

    // output side: random stalls plus one long hold-off on request
    initial
    begin
        int stall;
        point_ch.ready <= 1'b0;
        hold_taken = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_now && !hold_taken)
            begin
                point_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_taken = 1'b1;
            end
            point_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
            stall = idle_gap();
            if (stall > 0)
            begin
                point_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (byte_ch.valid && byte_ch.ready) || (point_ch.valid && point_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles, %0d results still expected",
                         idle_cycles, pending);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        int k;
        byte_ch.valid      <= 1'b0;
        byte_ch.byte_in    <= '0;
        byte_ch.final_byte <= 1'b0;
        rst_n              <= 1'b0;
        bytes_sent         = 0;
        strings_sent       = 0;
        no_gaps            = 1'b0;
        hold_now           = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < $size(DIRECTED); k++)
            send_byte(DIRECTED[k][7:0], DIRECTED[k][8]);

        while (bytes_sent < 320)
        begin
            no_gaps = ($urandom_range(0, 4) == 0);
            send_text();
        end

        // output blocked while input keeps coming
        hold_now = 1'b1;
        no_gaps = 1'b1;
        repeat (8) send_text();

        while (bytes_sent < ITEM_TARGET)
        begin
            no_gaps = ($urandom_range(0, 4) == 0);
            send_text();
        end
        byte_ch.valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d bytes in %0d strings: %0d code points, %0d end markers",
                 bytes_sent, strings_sent, points_seen, markers_seen);
        $display("output held off for %0d cycles once under back-to-back input (done=%0b)",
                 HOLD_CYCLES, hold_taken);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
